### rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared constants and controller/datapath interface types for the
// fixed-point Newton square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

	// Port widths of the item fields
	localparam int VALUE_W = 32;
	localparam int ROOT_W  = 24;

	// Defaults for the top-level parameters
	localparam int DEF_WIDTH     = 32;
	localparam int DEF_FRAC_BITS = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_EMIT
	} nsr_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;     // latch operand, seed guess
		logic div_init; // clear divider, reload dividend
		logic div_step; // one restoring step
		logic update;   // guess <= next guess
		logic emit;     // load output register
	} nsr_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic special;   // negative or zero operand
		logic div_last;  // final divider step this cycle
		logic converged; // next guess not below current guess
	} nsr_status_t;

endpackage

`default_nettype wire

### rtl/nsr_ctrl.sv
// ----------------------------------------------------------------------------
// nsr_ctrl
// Sequencer for the Newton square root: accept, iterate divide/update,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output nsr_pkg::nsr_cmd_t       cmd,
	input  wire nsr_pkg::nsr_status_t sts
);

	nsr_pkg::nsr_state_t state_q, state_nxt;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			nsr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = nsr_pkg::ST_CHECK;
				end
			end
			nsr_pkg::ST_CHECK: begin
				if (sts.special) begin
					state_nxt = nsr_pkg::ST_EMIT;
				end else begin
					cmd.div_init = 1'b1;
					state_nxt    = nsr_pkg::ST_DIV;
				end
			end
			nsr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = nsr_pkg::ST_UPDATE;
				end
			end
			nsr_pkg::ST_UPDATE: begin
				if (sts.converged) begin
					state_nxt = nsr_pkg::ST_EMIT;
				end else begin
					cmd.update = 1'b1;
					state_nxt  = nsr_pkg::ST_CHECK;
				end
			end
			nsr_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = nsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = nsr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/nsr_dp.sv
// ----------------------------------------------------------------------------
// nsr_dp
// Datapath: operand and guess registers, restoring bit-serial divider,
// Newton update and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsr_dp #(
	parameter int WIDTH     = nsr_pkg::DEF_WIDTH,
	parameter int FRAC_BITS = nsr_pkg::DEF_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic signed [nsr_pkg::VALUE_W-1:0] value,
	output logic [nsr_pkg::ROOT_W-1:0]        root,
	output logic                              invalid,
	input  wire nsr_pkg::nsr_cmd_t            cmd,
	output nsr_pkg::nsr_status_t              sts
);

	// Guess must hold both the operand and the value 1.0
	localparam int GW = (WIDTH > FRAC_BITS + 1) ? WIDTH : FRAC_BITS + 1;
	localparam int QW = GW + 1;              // quotient
	localparam int RW = GW + 1;              // partial remainder
	localparam int DW = WIDTH + FRAC_BITS;   // dividend x << FRAC_BITS
	localparam int CW = $clog2(DW);

	logic [WIDTH-1:0] opnd;
	logic [GW-1:0]    opnd_g, one_g, seed;

	logic [WIDTH-1:0] x_q;
	logic [GW-1:0]    guess_q;
	logic             neg_q, zero_q;
	logic [DW-1:0]    dvd_q;
	logic [RW-1:0]    rem_q;
	logic [QW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;

	logic [RW-1:0]    rem_sh, rem_sub;
	logic             take;
	logic [GW+1:0]    sum;
	logic [GW:0]      nxt;

	logic [nsr_pkg::ROOT_W-1:0] root_q;
	logic                       invalid_q;

	// Bits above WIDTH are dropped; WIDTH above the port width zero-fills
	assign opnd   = WIDTH'($unsigned(value));
	assign opnd_g = GW'(opnd);
	assign one_g  = GW'(1) << FRAC_BITS;
	assign seed   = (opnd_g > one_g) ? opnd_g : one_g;

	// Restoring step; remainder stays below the divisor so its top bit is free
	assign rem_sh  = {rem_q[RW-2:0], dvd_q[DW-1]};
	assign take    = rem_sh >= RW'(guess_q);
	assign rem_sub = rem_sh - RW'(guess_q);

	// next = floor((guess + q) / 2)
	assign sum = (GW + 2)'(guess_q) + (GW + 2)'(quo_q);
	assign nxt = sum[GW+1:1];

	assign sts.special   = neg_q || zero_q;
	assign sts.div_last  = cnt_q == CW'(DW - 1);
	assign sts.converged = nxt >= (GW + 1)'(guess_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			guess_q   <= '0;
			neg_q     <= 1'b0;
			zero_q    <= 1'b0;
			dvd_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			cnt_q     <= '0;
			root_q    <= '0;
			invalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				x_q     <= opnd;
				guess_q <= seed;
				neg_q   <= opnd[WIDTH-1];
				zero_q  <= opnd == '0;
			end else if (cmd.update) begin
				guess_q <= nxt[GW-1:0];
			end

			if (cmd.div_init) begin
				dvd_q <= DW'(x_q) << FRAC_BITS;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				dvd_q <= dvd_q << 1;
				rem_q <= take ? rem_sub : rem_sh;
				quo_q <= {quo_q[QW-2:0], take};
				cnt_q <= cnt_q + CW'(1);
			end

			if (cmd.emit) begin
				root_q    <= sts.special ? '0 : nsr_pkg::ROOT_W'(guess_q);
				invalid_q <= neg_q;
			end
		end
	end

	assign root    = root_q;
	assign invalid = invalid_q;

endmodule

`default_nettype wire

### rtl/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// Square root of a signed fixed-point operand by Newton iteration, with a
// shared restoring bit-serial divider; one item in flight at a time.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, value[31:0]  | into block
//  out     | out_valid, out_stall, root[23:0],| out of block
//          | invalid                          |
//
//  Each positive item takes a series of Newton steps, each a full pass of the
//  restoring divider; every step but the last also updates the guess. The divider makes
//  one quotient bit per cycle and takes up most of each item's time.
//  Negative and zero operands skip the divider and go straight to the output register.
//  Reset (arst_n low) empties the block and the output register.
//  A new item is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module newton_square_root #(
	parameter int WIDTH     = nsr_pkg::DEF_WIDTH,     // operand width
	parameter int FRAC_BITS = nsr_pkg::DEF_FRAC_BITS  // fraction bits
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [nsr_pkg::VALUE_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [nsr_pkg::ROOT_W-1:0]              root,
	output logic                                    invalid
);

	nsr_pkg::nsr_cmd_t    cmd;
	nsr_pkg::nsr_status_t sts;

	// Sequencer: accept, then per Newton step one divider pass and, until convergence, one update
	nsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Operand, guess, divider and output registers
	nsr_dp #(
		.WIDTH     (WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.root    (root),
		.invalid (invalid),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

`default_nettype wire

### verif/newton_square_root_tb.sv
// ----------------------------------------------------------------------------
// newton_square_root_tb
// Self-checking bench for the Newton square root. Operands go in over the
// valid/stall input channel. A scoreboard works out each root and the invalid
// flag, and checks every result that leaves the block against the oldest
// expected one. Traffic runs in three phases of sender idling and receiver
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module newton_square_root_tb;

	localparam logic [nsr_pkg::VALUE_W-1:0] ONE_FX = 32'h0001_0000; // 1.0 in Q16.16

	typedef struct {
		logic [nsr_pkg::ROOT_W-1:0] root;
		logic                       invalid;
	} root_item_t;

	// ------------------------------------------------------------------
	// Scoreboard: works out the root of each accepted operand and checks
	// the results in order.
	// ------------------------------------------------------------------
	class root_scoreboard;
		root_item_t pending_roots[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// Newton steps with a truncating divide and halving; the first guess
		// is max(x, 1.0), and the steps stop once the guess stops shrinking.
		function root_item_t newton_predict(logic [nsr_pkg::VALUE_W-1:0] x);
			logic [63:0] dividend;
			logic [63:0] guess;
			logic [63:0] quot;
			logic [63:0] nxt;
			root_item_t  r;
			r.root    = '0;
			r.invalid = 1'b0;
			if (x[nsr_pkg::VALUE_W-1]) begin
				r.invalid = 1'b1;
				return r;
			end
			if (x == 0)
				return r;
			dividend = {16'b0, x, 16'b0};
			guess    = (x > ONE_FX) ? {32'b0, x} : {32'b0, ONE_FX};
			while (guess != 0) begin
				quot = dividend / guess;
				nxt  = (guess >> 1) + (quot >> 1) + (guess & quot & 64'd1);
				if (nxt >= guess)
					break;
				guess = nxt;
			end
			r.root = guess[nsr_pkg::ROOT_W-1:0];
			return r;
		endfunction

		function void note_operand(logic [nsr_pkg::VALUE_W-1:0] x);
			pending_roots.push_back(newton_predict(x));
		endfunction

		function void check_root(logic [nsr_pkg::ROOT_W-1:0] root, logic invalid);
			root_item_t want;
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected result root=%h invalid=%b", $time, root, invalid);
				errors++;
				return;
			end
			want = pending_roots.pop_front();
			if (root !== want.root) begin
				$display("%0t: root mismatch, expected %h, got %h", $time, want.root, root);
				errors++;
			end
			if (invalid !== want.invalid) begin
				$display("%0t: invalid mismatch, expected %b, got %b",
					$time, want.invalid, invalid);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------
	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic                               in_stall;
	logic signed [nsr_pkg::VALUE_W-1:0] value     = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic [nsr_pkg::ROOT_W-1:0]         root;
	logic                               invalid;

	newton_square_root u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root),
		.invalid   (invalid)
	);

	root_scoreboard sb = new();

	// percentages of cycles the sender idles and the receiver stalls
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, reworked every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Both channels are sampled at the edge, before any NBA lands.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_operand(value);
		if (arst_n && out_valid && !out_stall)
			sb.check_root(root, invalid);
	end

	// Hand one operand over; returns at the edge that accepts it.
	// in_valid stays high into the next item unless the sender idles.
	task automatic send_operand(logic [nsr_pkg::VALUE_W-1:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= x;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Random operand: whole range, negatives, many magnitudes, values near
	// perfect squares and around 1.0.
	function automatic logic [nsr_pkg::VALUE_W-1:0] random_operand();
		logic [nsr_pkg::VALUE_W-1:0] x;
		int                          k;
		case ($urandom_range(9))
			0, 1, 2: x = $urandom;
			3:       x = {1'b1, 31'($urandom)};
			4, 5, 6: x = 32'($urandom) >> $urandom_range(1, 31);
			7:       x = $urandom_range(255);
			8: begin
				k = $urandom_range(1, 181);
				x = ((k * k) << 16) + $urandom_range(2) - 1;
			end
			default: x = ONE_FX + $urandom_range(512) - 256;
		endcase
		return x;
	endfunction

	// One edge first so the item accepted at the current edge is noted.
	task automatic wait_drained();
		@(posedge clk);
		while (sb.pending_roots.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [nsr_pkg::VALUE_W-1:0] directed_ops[] = '{
		32'h0000_0000,  // zero
		32'h0000_0001,  // smallest positive
		32'h0000_0002,
		32'h0000_FFFF,  // just below 1.0
		32'h0001_0000,  // 1.0
		32'h0001_0001,  // just above 1.0
		32'h0002_0000,  // 2.0
		32'h0004_0000,  // 4.0, exact square
		32'h0000_4000,  // 0.25
		32'h0009_0000,  // 9.0
		32'h0064_0000,  // 100.0
		32'h7FFF_0000,
		32'h7FFF_FFFF,  // largest positive
		32'h4000_0000,  // largest power of two
		32'h5555_5555,
		32'h2AAA_AAAA,
		32'hFFFF_FFFF,  // -2^-16
		32'h8000_0000,  // most negative
		32'hFFFF_0000,  // -1.0
		32'hAAAA_AAAA,
		32'h0000_0000   // zero after a negative
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 1: directed corners, then random; sender idles lightly
		send_idle_pct  = 11;
		recv_stall_pct = 45;
		foreach (directed_ops[i])
			send_operand(directed_ops[i]);
		repeat (230)
			send_operand(random_operand());

		// sender holds off until every root is back
		in_valid <= 1'b0;
		wait_drained();
		@(posedge clk);

		// phase 2: roles swapped
		send_idle_pct  = 45;
		recv_stall_pct = 11;
		repeat (250)
			send_operand(random_operand());

		// phase 3: back to back, no stalls
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (250)
			send_operand(random_operand());
		in_valid <= 1'b0;

		// drain, then a quiet stretch to catch any extra result
		wait_drained();
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.pending_roots.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Guard: roughly 750 items, each a full Newton sequence, with wide margin.
	initial begin
		#80_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
